// File: rtl/core/cde_pkg.sv
// Shared types and constants of the cosine distance engine.
`default_nettype none
package cde_pkg;

	localparam int MAX_LEN = 1024;
	localparam int EW      = 16;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int PP_W    = 2 * EW;
	localparam int NRM_W   = 2 * (EW - 1) + CNT_W;
	localparam int DOT_W   = NRM_W + 1;
	localparam int PROD_W  = 2 * NRM_W;
	localparam int M_W     = EW;
	localparam int SH      = 2 * (M_W - 1);
	localparam int CMP_W   = PROD_W + 2 * M_W;
	localparam int STEP_W  = $clog2(NRM_W);

	localparam logic [EW-1:0] ONE_Q14 = EW'(16384);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOVALID = 2'd1,
		ST_ZNORM   = 2'd2,
		ST_OVF     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [EW-1:0] elem_a;
		logic signed [EW-1:0] elem_b;
		logic                 a_missing;
		logic                 b_missing;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic [EW-1:0] distance;
		status_t       status;
	} result_t;

	typedef struct packed {
		logic take;
		logic eval;
		logic load_p;
		logic load_d;
		logic step;
		logic init;
		logic cand;
		logic decide;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic ok;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/cde_dp.sv
// Datapath: pair classification, accumulators, serial multiplier, root/divide search.
`default_nettype none
module cde_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  cde_pkg::item_t    item,
	input  cde_pkg::cmd_t     cmd,
	output cde_pkg::sts_t     sts,
	output cde_pkg::result_t  result
);
	import cde_pkg::*;

	logic [CNT_W-1:0]        ecnt_q;
	logic                    ovf_q;
	logic                    anyv_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [NRM_W-1:0]        na_q;
	logic [NRM_W-1:0]        nb_q;
	logic                    add_s1;
	logic                    valid_s1;
	logic signed [PP_W-1:0]  pab_s1;
	logic [PP_W-1:0]         paa_s1;
	logic [PP_W-1:0]         pbb_s1;
	logic                    hit_ovf;
	logic                    miss;
	logic                    za;
	logic                    zb;
	status_t                 st_q;
	status_t                 st_next;
	logic [NRM_W-1:0]        mag;
	logic [PROD_W-1:0]       xs_q;
	logic [NRM_W-1:0]        ys_q;
	logic [PROD_W-1:0]       pacc_q;
	logic [PROD_W-1:0]       p_q;
	logic [CMP_W-1:0]        ps_q;
	logic [CMP_W-1:0]        rs_q;
	logic [CMP_W-1:0]        qq_q;
	logic [CMP_W-1:0]        tt_q;
	logic [CMP_W-1:0]        cand_q;
	logic [CMP_W-1:0]        rs_sum;
	logic                    fit;
	logic [M_W-1:0]          m_q;
	logic [M_W:0]            msum;
	logic [EW-1:0]           tval;
	logic [DOT_W-1:0]        dot_neg;

	assign hit_ovf = ecnt_q >= CNT_W'(MAX_LEN);
	assign miss    = item.a_missing | item.b_missing;
	assign za      = item.elem_a == '0;
	assign zb      = item.elem_b == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			add_s1   <= cmd.take & ~hit_ovf & ~miss & ~za & ~zb;
			valid_s1 <= cmd.take & ~hit_ovf & ~miss & (za == zb);
		end
	end

	always_ff @(posedge clk) begin
		pab_s1 <= item.elem_a * item.elem_b;
		paa_s1 <= PP_W'(item.elem_a * item.elem_a);
		pbb_s1 <= PP_W'(item.elem_b * item.elem_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q <= '0;
			ovf_q  <= 1'b0;
			anyv_q <= 1'b0;
			dot_q  <= '0;
			na_q   <= '0;
			nb_q   <= '0;
		end else if (cmd.fin) begin
			ecnt_q <= '0;
			ovf_q  <= 1'b0;
			anyv_q <= 1'b0;
			dot_q  <= '0;
			na_q   <= '0;
			nb_q   <= '0;
		end else begin
			if (cmd.take) begin
				if (hit_ovf) begin
					ovf_q <= 1'b1;
				end else begin
					ecnt_q <= ecnt_q + CNT_W'(1);
				end
			end
			if (valid_s1) begin
				anyv_q <= 1'b1;
			end
			if (add_s1) begin
				dot_q <= dot_q + DOT_W'(pab_s1);
				na_q  <= na_q + NRM_W'(paa_s1);
				nb_q  <= nb_q + NRM_W'(pbb_s1);
			end
		end
	end

	always_comb begin
		if (ovf_q) begin
			st_next = ST_OVF;
		end else if (!anyv_q) begin
			st_next = ST_NOVALID;
		end else if (na_q == '0 || nb_q == '0) begin
			st_next = ST_ZNORM;
		end else begin
			st_next = ST_OK;
		end
	end

	assign sts.ok  = st_next == ST_OK;
	assign dot_neg = -dot_q;
	assign mag     = dot_q[DOT_W-1] ? dot_neg[NRM_W-1:0] : dot_q[NRM_W-1:0];

	// shift-add multiplier, one partial product per cycle
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			st_q <= st_next;
		end
		if (cmd.load_p) begin
			xs_q   <= PROD_W'(na_q);
			ys_q   <= nb_q;
			pacc_q <= '0;
		end else if (cmd.load_d) begin
			p_q    <= pacc_q;
			xs_q   <= PROD_W'(mag);
			ys_q   <= mag;
			pacc_q <= '0;
		end else if (cmd.step) begin
			if (ys_q[0]) begin
				pacc_q <= pacc_q + xs_q;
			end
			xs_q <= xs_q << 1;
			ys_q <= ys_q >> 1;
		end
	end

	// largest m with m^2 * na * nb <= 2^SH * dot^2, one bit per candidate and decide step pair
	assign fit    = cand_q <= tt_q;
	assign rs_sum = rs_q + (ps_q << 1);

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			ps_q <= CMP_W'(p_q) << SH;
			tt_q <= CMP_W'(pacc_q) << SH;
			rs_q <= '0;
			qq_q <= '0;
			m_q  <= '0;
		end else if (cmd.cand) begin
			cand_q <= qq_q + rs_q + ps_q;
		end else if (cmd.decide) begin
			if (fit) begin
				qq_q <= cand_q;
			end
			rs_q <= (fit ? rs_sum : rs_q) >> 1;
			ps_q <= ps_q >> 2;
			m_q  <= {m_q[M_W-2:0], fit};
		end
	end

	assign msum = {1'b0, m_q} + (M_W+1)'(1);
	assign tval = msum[M_W:1];

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result.status <= st_q;
			if (st_q != ST_OK) begin
				result.distance <= '0;
			end else if (dot_q[DOT_W-1]) begin
				result.distance <= ONE_Q14 + tval;
			end else begin
				result.distance <= ONE_Q14 - tval;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/cde_ctrl.sv
// Controller: input flow, finishing sequence and result valid.
`default_nettype none
module cde_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            item_valid,
	input  wire            item_last,
	output logic           item_stall,
	output logic           result_valid,
	input  wire            result_stall,
	output cde_pkg::cmd_t  cmd,
	input  cde_pkg::sts_t  sts
);
	import cde_pkg::*;

	typedef enum logic [3:0] {
		S_RUN,
		S_DRAIN,
		S_EVAL,
		S_MULP,
		S_SAVEP,
		S_MULD,
		S_SRI,
		S_SRA,
		S_SRB,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              res_valid_q;
	logic              free;

	assign free         = ~res_valid_q | ~result_stall;
	assign item_stall   = state_q != S_RUN;
	assign result_valid = res_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.take   = item_valid & (state_q == S_RUN);
		cmd.eval   = state_q == S_EVAL;
		cmd.load_p = (state_q == S_EVAL) & sts.ok;
		cmd.load_d = state_q == S_SAVEP;
		cmd.step   = (state_q == S_MULP) | (state_q == S_MULD);
		cmd.init   = state_q == S_SRI;
		cmd.cand   = state_q == S_SRA;
		cmd.decide = state_q == S_SRB;
		cmd.fin    = (state_q == S_FIN) & free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q & result_stall) | cmd.fin;
			case (state_q)
				S_RUN: begin
					if (item_valid && item_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_EVAL;
				S_EVAL: begin
					cnt_q   <= '0;
					state_q <= sts.ok ? S_MULP : S_FIN;
				end
				S_MULP: begin
					if (cnt_q == STEP_W'(NRM_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SAVEP;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				S_SAVEP: state_q <= S_MULD;
				S_MULD: begin
					if (cnt_q == STEP_W'(NRM_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SRI;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				S_SRI: state_q <= S_SRA;
				S_SRA: state_q <= S_SRB;
				S_SRB: begin
					if (cnt_q == STEP_W'(M_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q   <= cnt_q + STEP_W'(1);
						state_q <= S_SRA;
					end
				end
				S_FIN: begin
					if (free) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/cosine_distance_engine_unit.sv
// Top level of the cosine distance engine.
`default_nettype none
// One element pair beat is taken per cycle while a vector streams in. After
// the beat flagged last, the input stalls while the result is formed. When
// the status is not ok the drain and evaluate states lead straight to the
// finish state; otherwise a bit-serial multiplier forms the norm product and
// the squared dot product in turn, and a search finds the 16-bit similarity
// one bit per pair of candidate and decide steps. The result beat sits in
// an output register; a new vector may stream in while it waits to be taken.
// distance is unsigned Q2.14 (16384 = 1.0), 0 on any non-ok status.
module cosine_distance_engine_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_stall,
	input  cde_pkg::item_t    item,
	output logic              result_valid,
	input  wire               result_stall,
	output cde_pkg::result_t  result
);
	import cde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cde_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	cde_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
`default_nettype wire
